>>> src/file_uri_percent_decoder_top_macros.svh
// Assertion macros for the file URI percent decoder.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef FILE_URI_PERCENT_DECODER_TOP_MACROS_SVH
`define FILE_URI_PERCENT_DECODER_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define FUD_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fud: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define FUD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fud: next-cycle check failed");

`endif

>>> src/fud_pkg.sv
// Shared types, constants and character tables of the file URI percent decoder.
// No dependencies; used by fud_step, file_uri_percent_decoder_top and fud_checker.
`timescale 1ns / 1ps

package fud_pkg;

  localparam int unsigned PrefixLen = 7;
  localparam int unsigned LocalLen  = 10;

  localparam logic [7:0] CharPercent = 8'h25;
  localparam logic [7:0] CharSlash   = 8'h2F;

  typedef enum logic [2:0] {
    PH_PREFIX,
    PH_LOCAL,
    PH_BODY,
    PH_ESC1,
    PH_ESC2
  } phase_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       is_last;
    logic       is_error;
  } out_t;

  typedef struct packed {
    phase_e     phase;
    logic [3:0] match_index;
    logic [3:0] high_nibble;
    logic       error_seen;
  } state_t;

  typedef struct packed {
    logic [3:0] replay_cnt;
    logic       tail_valid;
    out_t       tail;
    state_t     next;
  } step_t;

  localparam state_t StateReset = '{
    phase:       PH_PREFIX,
    match_index: 4'd0,
    high_nibble: 4'd0,
    error_seen:  1'b0
  };

  localparam out_t ErrorBeat = '{
    out_byte: 8'd0, byte_valid: 1'b0, is_last: 1'b1, is_error: 1'b1
  };

  localparam out_t EmptyLastBeat = '{
    out_byte: 8'd0, byte_valid: 1'b0, is_last: 1'b1, is_error: 1'b0
  };

  // "file://"
  function automatic logic [7:0] prefix_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h66;
      4'd1:    c = 8'h69;
      4'd2:    c = 8'h6C;
      4'd3:    c = 8'h65;
      4'd4:    c = 8'h3A;
      4'd5:    c = 8'h2F;
      4'd6:    c = 8'h2F;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "localhost/"
  function automatic logic [7:0] local_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h6C;
      4'd1:    c = 8'h6F;
      4'd2:    c = 8'h63;
      4'd3:    c = 8'h61;
      4'd4:    c = 8'h6C;
      4'd5:    c = 8'h68;
      4'd6:    c = 8'h6F;
      4'd7:    c = 8'h73;
      4'd8:    c = 8'h74;
      4'd9:    c = 8'h2F;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Bit 4 set means not a hex digit.
  function automatic logic [4:0] hex_of(input logic [7:0] b);
    logic [4:0] v;
    if (b inside {[8'h30:8'h39]}) begin
      v = {1'b0, b[3:0]};
    end else if (b inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      v = {1'b0, b[3:0] + 4'd9};
    end else begin
      v = 5'h10;
    end
    return v;
  endfunction

endpackage

>>> src/file_uri_percent_decoder_top.sv
// Top level of the file URI percent decoder: input slot, replay counter and
// output register. Depends on fud_pkg and fud_step.
`timescale 1ns / 1ps

// Feed a "file://" URI one byte per beat, in_last on its final byte; the block
// returns the decoded local path one byte per beat, the closing beat marked
// is_last, with is_error set there if the URI was rejected (earlier path beats
// of a rejected URI are to be discarded). It takes one byte per cycle unless
// stalled. A byte that breaks a partial "localhost/" match, or ends the URI
// inside one, holds the input while each replayed letter (up to nine) goes
// out, since the single output register sends one result beat per cycle
// while out_stall_i is low. Bytes that yield no result (the prefix, escape
// digits, bytes after a rejection) still pass through the input slot.
module file_uri_percent_decoder_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  fud_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output fud_pkg::out_t out_data_o
);

  logic            item_valid_q, item_valid_d;
  fud_pkg::in_t    item_q;
  logic [3:0]      cnt_q, cnt_d;
  fud_pkg::state_t st_q, st_d;
  logic            out_valid_q, out_valid_d;
  fud_pkg::out_t   out_q, out_d;
  fud_pkg::step_t  step;

  logic accept;
  logic out_free;
  logic at_tail;
  logic push_letter;
  logic push_tail;
  logic retire;

  fud_step u_step (
    .st_i   (st_q),
    .beat_i (item_q),
    .step_o (step)
  );

  assign out_free    = !out_valid_q || !out_stall_i;
  assign at_tail     = item_valid_q && (cnt_q == step.replay_cnt);
  assign push_letter = item_valid_q && (cnt_q != step.replay_cnt) && out_free;
  assign push_tail   = at_tail && step.tail_valid && out_free;
  assign retire      = at_tail && (!step.tail_valid || out_free);
  assign in_stall_o  = item_valid_q && !retire;
  assign accept      = in_valid_i && !in_stall_o;

  always_comb begin
    item_valid_d = item_valid_q;
    if (accept) begin
      item_valid_d = 1'b1;
    end else if (retire) begin
      item_valid_d = 1'b0;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    st_d  = st_q;
    if (push_letter) begin
      cnt_d = cnt_q + 4'd1;
    end else if (retire) begin
      cnt_d = 4'd0;
      st_d  = step.next;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (push_letter) begin
      out_valid_d = 1'b1;
      out_d = '{out_byte: fud_pkg::local_char(cnt_q), byte_valid: 1'b1,
                is_last: 1'b0, is_error: 1'b0};
    end else if (push_tail) begin
      out_valid_d = 1'b1;
      out_d       = step.tail;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      cnt_q        <= 4'd0;
      st_q         <= fud_pkg::StateReset;
      out_valid_q  <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
      cnt_q        <= cnt_d;
      st_q         <= st_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> src/fud_step.sv
// Per-byte decode step: from the current state and one input beat, the number
// of "localhost" letters to replay, the optional result beat and next state.
// Depends on fud_pkg.
`timescale 1ns / 1ps

module fud_step (
  input  fud_pkg::state_t st_i,
  input  fud_pkg::in_t    beat_i,
  output fud_pkg::step_t  step_o
);

  logic [7:0]      b;
  logic            last;
  logic [3:0]      idx;
  logic [4:0]      hex;
  logic [3:0]      r;
  logic [3:0]      r_m1;
  logic            emit;
  logic [7:0]      emit_byte;
  logic            err;
  logic            body_en;
  fud_pkg::phase_e body_ph;
  fud_pkg::state_t ns;
  fud_pkg::out_t   tail;
  logic            tail_v;

  assign b    = beat_i.in_byte;
  assign last = beat_i.in_last;
  assign idx  = st_i.match_index;
  assign hex  = fud_pkg::hex_of(b);

  always_comb begin
    ns        = st_i;
    r         = 4'd0;
    emit      = 1'b0;
    emit_byte = 8'd0;
    err       = 1'b0;
    body_en   = 1'b0;
    body_ph   = st_i.phase;

    case (st_i.phase)
      fud_pkg::PH_PREFIX: begin
        if (idx < 4'(fud_pkg::PrefixLen) && b == fud_pkg::prefix_char(idx)) begin
          if (idx == 4'(fud_pkg::PrefixLen - 1)) begin
            ns.phase       = fud_pkg::PH_LOCAL;
            ns.match_index = 4'd0;
          end else begin
            ns.match_index = idx + 4'd1;
            if (last) begin
              err = 1'b1;
            end
          end
        end else begin
          err = 1'b1;
        end
      end
      fud_pkg::PH_LOCAL: begin
        if (idx < 4'(fud_pkg::LocalLen) && b == fud_pkg::local_char(idx)) begin
          if (idx == 4'(fud_pkg::LocalLen - 1)) begin
            emit           = 1'b1;
            emit_byte      = fud_pkg::CharSlash;
            ns.phase       = fud_pkg::PH_BODY;
            ns.match_index = 4'd0;
          end else begin
            ns.match_index = idx + 4'd1;
            if (last) begin
              r              = idx + 4'd1;
              ns.match_index = 4'd0;
              ns.phase       = fud_pkg::PH_BODY;
            end
          end
        end else begin
          r              = idx;
          ns.match_index = 4'd0;
          body_en        = 1'b1;
          body_ph        = fud_pkg::PH_BODY;
        end
      end
      default: begin
        body_en = 1'b1;
      end
    endcase

    if (body_en) begin
      case (body_ph)
        fud_pkg::PH_ESC1: begin
          if (hex[4]) begin
            err = 1'b1;
          end else begin
            ns.high_nibble = hex[3:0];
            ns.phase       = fud_pkg::PH_ESC2;
          end
        end
        fud_pkg::PH_ESC2: begin
          if (hex[4] || (st_i.high_nibble == 4'd0 && hex[3:0] == 4'd0)) begin
            err = 1'b1;
          end else begin
            emit           = 1'b1;
            emit_byte      = {st_i.high_nibble, hex[3:0]};
            ns.high_nibble = 4'd0;
            ns.phase       = fud_pkg::PH_BODY;
          end
        end
        default: begin
          ns.phase = fud_pkg::PH_BODY;
          if (b == fud_pkg::CharPercent) begin
            ns.phase = fud_pkg::PH_ESC1;
          end else begin
            emit      = 1'b1;
            emit_byte = b;
          end
        end
      endcase
    end

    // truncated escape
    if (!err && last && (ns.phase == fud_pkg::PH_ESC1 || ns.phase == fud_pkg::PH_ESC2)) begin
      err = 1'b1;
    end
  end

  assign r_m1 = r - 4'd1;

  always_comb begin
    step_o = '0;
    tail   = '0;
    tail_v = 1'b0;
    step_o.replay_cnt = r;
    step_o.next       = ns;

    if (st_i.error_seen) begin
      step_o.replay_cnt = 4'd0;
      step_o.next       = st_i;
      if (last) begin
        tail_v      = 1'b1;
        tail        = fud_pkg::ErrorBeat;
        step_o.next = fud_pkg::StateReset;
      end
    end else if (err) begin
      if (last) begin
        tail_v      = 1'b1;
        tail        = fud_pkg::ErrorBeat;
        step_o.next = fud_pkg::StateReset;
      end else begin
        step_o.next.error_seen = 1'b1;
      end
    end else if (last) begin
      tail_v = 1'b1;
      if (emit) begin
        tail = '{out_byte: emit_byte, byte_valid: 1'b1, is_last: 1'b1, is_error: 1'b0};
      end else if (r != 4'd0) begin
        // move the final replayed letter into the closing result
        step_o.replay_cnt = r_m1;
        tail = '{out_byte: fud_pkg::local_char(r_m1), byte_valid: 1'b1,
                 is_last: 1'b1, is_error: 1'b0};
      end else begin
        tail = fud_pkg::EmptyLastBeat;
      end
      step_o.next = fud_pkg::StateReset;
    end else if (emit) begin
      tail_v = 1'b1;
      tail   = '{out_byte: emit_byte, byte_valid: 1'b1, is_last: 1'b0, is_error: 1'b0};
    end

    step_o.tail_valid = tail_v;
    step_o.tail       = tail;
  end

endmodule

>>> src/fud_checker.sv
// Port-level checks of the file URI percent decoder, bound to its top level.
// Depends on fud_pkg and file_uri_percent_decoder_top_macros.svh.
`timescale 1ns / 1ps
`include "file_uri_percent_decoder_top_macros.svh"

module fud_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input fud_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input fud_pkg::out_t out_data_o
);

  `FUD_ASSERT_NEXT(a_in_hold, in_valid_i && in_stall_o, in_valid_i && $stable(in_data_i))
  `FUD_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))
  `FUD_ASSERT_IMPLY(a_err_on_close, out_valid_o && out_data_o.is_error, out_data_o.is_last && !out_data_o.byte_valid)
  `FUD_ASSERT_IMPLY(a_empty_is_close, out_valid_o && !out_data_o.byte_valid, out_data_o.is_last)
  `FUD_ASSERT_IMPLY(a_empty_zero, out_valid_o && !out_data_o.byte_valid, out_data_o.out_byte == 8'd0)

endmodule

bind file_uri_percent_decoder_top fud_checker u_fud_checker (.*);
